>>> sv/bitmap_page_allocator_mapper_core_defines.svh
// Assertion macros for the page allocator/mapper RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef BITMAP_PAGE_ALLOCATOR_MAPPER_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_MAPPER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BPAM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPAM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPAM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BPAM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/bpam_pkg.sv
// Shared types and constants of the page allocator/mapper.
// Depends on nothing.
package bpam_pkg;

    localparam logic [31:0] HEAP_BASE   = 32'hc010_0000;
    localparam logic [31:0] PHYS_BASE   = 32'h0020_0000;
    localparam logic [31:0] ENTRY_FLAGS = 32'h0000_0007;
    localparam int          MAX_COUNT   = 64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_VIRT = 2'd1,
        ST_NO_PHYS = 2'd2
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [6:0] run_pages;
    } t_in;

    typedef struct packed {
        logic [31:0] virt_page_addr;
        logic [31:0] pte_value;
        logic [9:0]  dir_index;
        logic        new_table;
        logic [31:0] dir_value;
        t_status     status;
        logic        last;
    } t_out;

endpackage

>>> sv/bpam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bpam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/bitmap_page_allocator_mapper_core.sv
// Top level of the kernel page-run allocator and mapper.
// Depends on bpam_pkg, bpam_ram and bitmap_page_allocator_mapper_core_defines.svh.
//
// A transfer on the input asks for a run of contiguous kernel virtual pages.
// The block finds the first free run in the virtual bitmap, marks it, then for
// each page takes the lowest free physical page and returns one mapping item;
// failures end the request with a single item carrying a nonzero status.
// Both bitmaps live in RAMs of 32-bit words (POOL_PAGES/32 words each, rounded
// up). After reset a clearing pass of one cycle per word zeroes them, during
// which no request is taken. The virtual search steps one bit per cycle, after
// a read of each word it enters; marking reads each word touched, sets its bits
// and writes it back; each page then scans the physical bitmap one word at a
// time from word zero until a free bit shows, writes that word back and loads
// the mapping item once the output register is free. The block takes
// one request at a time and holds o_in_stall high until its last item is loaded.
// All pages lie at or above directory entry 768, whose entries are present
// from reset on, so new_table and dir_value are always zero.
`include "bitmap_page_allocator_mapper_core_defines.svh"
module bitmap_page_allocator_mapper_core #(
    parameter int POOL_PAGES = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [29:0]     i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bpam_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bpam_pkg::t_out  o_out_data
);
    localparam int WORDS   = (POOL_PAGES + 31) / 32;
    localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SPAN_W  = $clog2(POOL_PAGES + 1);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_VRD, S_VWT, S_VBIT, S_MRD, S_MWT, S_MBIT, S_MWR,
        S_PRD, S_PWT, S_PCHK, S_PWR, S_EMIT
    } t_state;

    t_state          r_state;
    logic [29:0]     r_mem;
    logic [WA_W-1:0] r_clr;
    logic [SPAN_W-1:0] r_span, r_i, r_start, r_j, r_end;
    logic [6:0]      r_run, r_count, r_k;
    logic [WA_W:0]   r_pw;
    logic [WA_W-1:0] r_wa;
    logic [31:0]     r_word;
    bpam_pkg::t_out  r_pend, r_out;
    logic            r_ovalid;

    // Pool span from the installed memory size.
    logic [29:0] w_diff;
    logic [31:0] w_bits, w_span;
    always_comb begin
        w_diff = r_mem - 30'h20_0000;
        w_bits = {15'd0, w_diff[29:16], 3'd0};
        if (r_mem < 30'h20_0000) begin
            w_span = 32'd0;
        end else if (w_bits > 32'(POOL_PAGES)) begin
            w_span = 32'(POOL_PAGES);
        end else begin
            w_span = w_bits;
        end
    end

    // Lowest free in-span bit of the current physical word.
    logic [4:0] w_pb;
    logic       w_pfound;
    always_comb begin
        w_pb = 5'd0;
        w_pfound = 1'b0;
        for (int b = 31; b >= 0; b--) begin
            if (!r_word[b] && (((32'(r_pw) << 5) | 32'(b)) < 32'(r_span))) begin
                w_pb = 5'(b);
                w_pfound = 1'b1;
            end
        end
    end

    logic [31:0] w_va, w_pa;
    assign w_va = bpam_pkg::HEAP_BASE + ((32'(r_start) + 32'(r_k)) << 12);
    assign w_pa = bpam_pkg::PHYS_BASE + (((32'(r_pw) << 5) | 32'(w_pb)) << 12);

    // RAM ports.
    logic            v_we, p_we;
    logic [WA_W-1:0] v_waddr, p_waddr, v_raddr, p_raddr;
    logic [31:0]     v_wdata, p_wdata, v_rdata, p_rdata;
    always_comb begin
        v_we = 1'b0;  v_waddr = r_wa;  v_wdata = r_word;
        p_we = 1'b0;  p_waddr = r_wa;  p_wdata = r_word;
        v_raddr = r_i[5 +: WA_W];
        p_raddr = r_pw[WA_W-1:0];
        unique case (r_state)
            S_CLR: begin
                v_we = 1'b1;  v_waddr = r_clr;  v_wdata = '0;
                p_we = 1'b1;  p_waddr = r_clr;  p_wdata = '0;
            end
            S_MRD:   v_raddr = r_j[5 +: WA_W];
            S_MWR:   v_we = 1'b1;
            S_PWR:   p_we = 1'b1;
            default: ;
        endcase
    end

    bpam_ram #(.WIDTH(32), .DEPTH(WORDS)) u_virt (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata));

    bpam_ram #(.WIDTH(32), .DEPTH(WORDS)) u_phys (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata));

    logic w_fail_item;
    assign w_fail_item = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_mem    <= 30'd33554432;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mem <= i_cfg_wdata;
            end
            // The emit state handles the output register on its own.
            if (r_ovalid && !i_out_stall && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == WORDS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_span  <= SPAN_W'(w_span);
                        r_count <= i_in_data.run_pages;
                        r_i     <= '0;
                        r_run   <= '0;
                        r_pend  <= '{virt_page_addr: 32'd0, pte_value: 32'd0,
                                     dir_index: 10'd0, new_table: w_fail_item,
                                     dir_value: 32'd0, status: bpam_pkg::ST_NO_VIRT,
                                     last: 1'b1};
                        if (i_in_data.mode || i_in_data.run_pages == 7'd0 ||
                            32'(i_in_data.run_pages) > bpam_pkg::MAX_COUNT) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_VRD;
                        end
                    end
                end
                S_VRD:  r_state <= (r_i == r_span) ? S_EMIT : S_VWT;
                S_VWT: begin
                    r_word  <= v_rdata;
                    r_state <= S_VBIT;
                end
                S_VBIT: begin
                    if (r_word[r_i[4:0]]) begin
                        r_run <= '0;
                    end else begin
                        if (r_run == 7'd0) begin
                            r_start <= r_i;
                        end
                        r_run <= r_run + 1'b1;
                    end
                    if (!r_word[r_i[4:0]] && r_run + 1'b1 == r_count) begin
                        r_j     <= (r_run == 7'd0) ? r_i : r_start;
                        r_end   <= ((r_run == 7'd0) ? r_i : r_start) + SPAN_W'(r_count);
                        r_state <= S_MRD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_i[4:0] == 5'd31 || r_i + 1'b1 == r_span) begin
                            r_state <= S_VRD;
                        end
                    end
                end
                S_MRD: begin
                    r_wa    <= r_j[5 +: WA_W];
                    r_state <= S_MWT;
                end
                S_MWT: begin
                    r_word  <= v_rdata;
                    r_state <= S_MBIT;
                end
                S_MBIT: begin
                    r_word[r_j[4:0]] <= 1'b1;
                    r_j <= r_j + 1'b1;
                    if (r_j + 1'b1 == r_end || r_j[4:0] == 5'd31) begin
                        r_state <= S_MWR;
                    end
                end
                S_MWR: begin
                    if (r_j == r_end) begin
                        r_k     <= '0;
                        r_pw    <= '0;
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                S_PRD: begin
                    r_wa    <= r_pw[WA_W-1:0];
                    r_state <= S_PWT;
                end
                S_PWT: begin
                    r_word  <= p_rdata;
                    r_state <= S_PCHK;
                end
                S_PCHK: begin
                    r_pend.virt_page_addr <= w_va;
                    r_pend.dir_index      <= w_va[31:22];
                    r_pend.new_table      <= 1'b0;
                    r_pend.dir_value      <= 32'd0;
                    if (w_pfound) begin
                        r_word[w_pb]     <= 1'b1;
                        r_pend.pte_value <= w_pa | bpam_pkg::ENTRY_FLAGS;
                        r_pend.status    <= bpam_pkg::ST_OK;
                        r_pend.last      <= (r_k + 1'b1 == r_count);
                        r_state          <= S_PWR;
                    end else if (((32'(r_pw) + 32'd1) << 5) >= 32'(r_span)) begin
                        r_pend.pte_value <= 32'd0;
                        r_pend.status    <= bpam_pkg::ST_NO_PHYS;
                        r_pend.last      <= 1'b1;
                        r_state          <= S_EMIT;
                    end else begin
                        r_pw    <= r_pw + 1'b1;
                        r_state <= S_PRD;
                    end
                end
                S_PWR:  r_state <= S_EMIT;
                S_EMIT: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_pend;
                        r_ovalid <= 1'b1;
                        if (r_pend.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_pw    <= '0;
                            r_state <= S_PRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // An accepted request always starts work on the next cycle.
    `BPAM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // Marking never runs past the visible pool.
    `BPAM_ASSERT_IMP(a_mark_in_span, i_clk, i_rst_n, r_state == S_MBIT, r_j < r_span)
    // A successful mapping always carries the entry flags.
    `BPAM_ASSERT_IMP(a_ok_flags, i_clk, i_rst_n,
        o_out_valid && o_out_data.status == bpam_pkg::ST_OK, o_out_data.pte_value[2:0] == 3'b111)
endmodule

>>> tb/bpam_checker.sv
// Scoreboard for the page allocator/mapper: watches the config port and both
// channels, predicts the mapping items of each request and compares them.
// Depends on bpam_pkg.
module bpam_checker
    import bpam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [29:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_maps_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES = 4096;

    logic        virt_taken [PAGES];
    logic        phys_taken [PAGES];
    logic        dir_present [1024];
    logic [29:0] mem_bytes;
    t_out        expected_maps [$];
    int          errors;
    int          pending;
    int          maps_seen;

    assign o_errors    = errors;
    assign o_pending   = pending;
    assign o_maps_seen = maps_seen;

    task automatic report(input string what);
        errors++;
        if (errors <= 40)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic int unsigned pool_span();
        int unsigned half;
        int unsigned bits;
        if (mem_bytes < PHYS_BASE)
            return 0;
        half = ((mem_bytes - PHYS_BASE) / 4096) / 2;
        bits = (half / 8) * 8;
        return (bits > PAGES) ? PAGES : bits;
    endfunction

    // Lowest free physical page, or -1 when the pool is used up.
    function automatic int grab_phys(input int unsigned span);
        for (int i = 0; i < span; i++)
            if (!phys_taken[i]) begin
                phys_taken[i] = 1'b1;
                return i;
            end
        return -1;
    endfunction

    function automatic t_out fail_item(input logic [31:0] va, input t_status st);
        t_out item;
        item = '0;
        item.virt_page_addr = va;
        item.dir_index = va[31:22];
        item.status = st;
        item.last = 1'b1;
        return item;
    endfunction

    function automatic void map_request(input t_in req);
        int unsigned span;
        int unsigned count;
        int unsigned first;
        int unsigned run;
        bit          found;
        int          pa;
        int          ta;
        logic [31:0] va;
        t_out        item;
        span = pool_span();
        count = req.run_pages;
        first = 0;
        run = 0;
        found = 0;
        if (req.mode || count == 0 || count > MAX_COUNT) begin
            expected_maps.push_back(fail_item('0, ST_NO_VIRT));
            return;
        end
        for (int i = 0; i < span && !found; i++) begin
            if (virt_taken[i]) begin
                run = 0;
            end else begin
                if (run == 0)
                    first = i;
                run++;
                if (run == count)
                    found = 1;
            end
        end
        if (!found) begin
            expected_maps.push_back(fail_item('0, ST_NO_VIRT));
            return;
        end
        for (int i = 0; i < count; i++)
            virt_taken[first + i] = 1'b1;
        for (int i = 0; i < count; i++) begin
            va = HEAP_BASE + (first + i) * 4096;
            pa = grab_phys(span);
            if (pa < 0) begin
                expected_maps.push_back(fail_item(va, ST_NO_PHYS));
                return;
            end
            item = '0;
            item.virt_page_addr = va;
            item.dir_index = va[31:22];
            item.pte_value = (PHYS_BASE + pa * 4096) | ENTRY_FLAGS;
            if (!dir_present[va[31:22]]) begin
                ta = grab_phys(span);
                if (ta < 0) begin
                    expected_maps.push_back(fail_item(va, ST_NO_PHYS));
                    return;
                end
                dir_present[va[31:22]] = 1'b1;
                item.new_table = 1'b1;
                item.dir_value = (PHYS_BASE + ta * 4096) | ENTRY_FLAGS;
            end
            item.status = ST_OK;
            item.last = (i + 1 == count);
            expected_maps.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            mem_bytes = 30'd33554432;
            for (int i = 0; i < PAGES; i++) begin
                virt_taken[i] = 1'b0;
                phys_taken[i] = 1'b0;
            end
            for (int i = 0; i < 1024; i++)
                dir_present[i] = (i >= 768);
            expected_maps.delete();
        end else begin
            if (i_cfg_we)
                mem_bytes = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                map_request(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                maps_seen++;
                if (expected_maps.size() == 0) begin
                    report($sformatf("unexpected item va=%h", i_out_data.virt_page_addr));
                end else begin
                    want = expected_maps.pop_front();
                    if (i_out_data.virt_page_addr !== want.virt_page_addr)
                        report($sformatf("virt_page_addr %h, want %h",
                            i_out_data.virt_page_addr, want.virt_page_addr));
                    if (i_out_data.pte_value !== want.pte_value)
                        report($sformatf("pte_value %h, want %h",
                            i_out_data.pte_value, want.pte_value));
                    if (i_out_data.dir_index !== want.dir_index)
                        report($sformatf("dir_index %0d, want %0d",
                            i_out_data.dir_index, want.dir_index));
                    if (i_out_data.new_table !== want.new_table)
                        report($sformatf("new_table %b, want %b",
                            i_out_data.new_table, want.new_table));
                    if (i_out_data.dir_value !== want.dir_value)
                        report($sformatf("dir_value %h, want %h",
                            i_out_data.dir_value, want.dir_value));
                    if (i_out_data.status !== want.status)
                        report($sformatf("status %0d, want %0d",
                            i_out_data.status, want.status));
                    if (i_out_data.last !== want.last)
                        report($sformatf("last %b, want %b",
                            i_out_data.last, want.last));
                end
            end
        end
        pending = expected_maps.size();
    end

    initial begin
        errors = 0;
        pending = 0;
        maps_seen = 0;
    end
endmodule

>>> tb/bitmap_page_allocator_mapper_core_test.sv
// Testbench top for the page allocator/mapper: makes clock, reset, config
// writes and requests, and gives the verdict. Depends on bpam_pkg,
// bpam_checker and the block itself.
module bitmap_page_allocator_mapper_core_test;
    import bpam_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [29:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    int          errors;
    int          pending;
    int          maps_seen;
    int          requests_sent;
    bit          quiet;     // set for the final stretch: no idling on either side

    bitmap_page_allocator_mapper_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    bpam_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_maps_seen (maps_seen)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Offers one request and returns at the edge where its transfer happens.
    // Valid stays high into the next request unless a random gap is drawn.
    task automatic send_request(input logic mode, input logic [6:0] count);
        int gap;
        in_valid <= 1'b1;
        in_data.mode <= mode;
        in_data.run_pages <= count;
        @(posedge i_clk);
        while (in_stall)
            @(posedge i_clk);
        requests_sent++;
        if (!quiet && $urandom_range(3) == 0) begin
            gap = $urandom_range(11, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed kernel requests of small size; a few big or bad ones.
    task automatic send_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            send_request(1'b1, 7'($urandom_range(127)));
        else if (pick < 9)
            send_request(1'b0, ($urandom_range(1)) ? 7'd0 : 7'($urandom_range(127, 65)));
        else if (pick < 22)
            send_request(1'b0, 7'($urandom_range(64, 9)));
        else
            send_request(1'b0, 7'($urandom_range(8, 1)));
    endtask

    // Lowers valid, waits for every predicted item, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_memory_size(input logic [29:0] bytes);
        cfg_we <= 1'b1;
        cfg_wdata <= bytes;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver side: random stall bursts until the quiet stretch begins.
    initial begin
        out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(30, 1)) @(posedge i_clk);
            if (!quiet) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(11, 1)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        quiet = 1'b0;
        requests_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset memory size: bad requests of each kind,
        // the run-length extremes and every bit of the count field.
        send_request(1'b1, 7'd5);
        send_request(1'b1, 7'd127);
        send_request(1'b0, 7'd0);
        send_request(1'b0, 7'd65);
        send_request(1'b0, 7'd127);
        send_request(1'b0, 7'd1);
        send_request(1'b0, 7'd64);
        send_request(1'b0, 7'd2);
        send_request(1'b0, 7'd63);
        send_request(1'b0, 7'd1);
        drain();

        // Memory below the pool base, then exactly at 2 MiB: the pool is empty.
        write_memory_size(30'd0);
        send_request(1'b0, 7'd1);
        send_request(1'b0, 7'd3);
        drain();
        write_memory_size(30'd2097152);
        send_request(1'b0, 7'd1);
        send_request(1'b0, 7'd64);
        drain();

        // A 64-page pool that the earlier requests have already filled,
        // so every request runs out of virtual space.
        write_memory_size(30'(32'h0020_0000 + 128 * 4096));
        send_request(1'b0, 7'd1);
        send_request(1'b0, 7'd8);
        drain();

        // Largest pool at the top of the register range.
        write_memory_size(30'd536870912);
        repeat (80) send_random_request();
        drain();
        write_memory_size(30'h3fff_ffff);
        repeat (70) send_random_request();
        drain();

        // Back to the reset size, with no idling on either side.
        write_memory_size(30'd33554432);
        quiet = 1'b1;
        repeat (60) send_random_request();
        drain();

        $display("Sent %0d requests over six memory sizes, including empty and full pools.",
            requests_sent);
        $display("Checked %0d mapping items field by field.", maps_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
